// ===== rtl/label_border_majority_smoother_assert.svh =====
// Assertion macros shared by the label border majority smoother.
`ifndef LABEL_BORDER_MAJORITY_SMOOTHER_ASSERT_SVH
`define LABEL_BORDER_MAJORITY_SMOOTHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBMS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBMS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lbms_pkg.sv =====
`default_nettype none
package lbms_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [2:0] REG_GRID_WIDTH    = 3'd0;
	localparam logic [2:0] REG_GRID_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_FIRST_LABEL   = 3'd2;
	localparam logic [2:0] REG_WINDOW_RADIUS = 3'd3;
	localparam logic [2:0] REG_MAX_PASSES    = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RUN_INIT,
		S_CELL_RD,
		S_CELL_CHK,
		S_NB_RD,
		S_NB_CHK,
		S_WIN_RD,
		S_WIN_CHK,
		S_DECIDE,
		S_WR,
		S_PASS_END,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic elect;
		logic count;
	} vote_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/lbms_ram.sv =====
`default_nettype none
module lbms_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/lbms_vote.sv =====
`default_nettype none
module lbms_vote import lbms_pkg::*; #(
	parameter int LABEL_BITS = 16,
	parameter int MAX_RADIUS = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire vote_ctl_t             ctl,
	input  wire logic [LABEL_BITS-1:0] lbl,
	input  wire logic [LABEL_BITS-1:0] own,
	output logic      [LABEL_BITS-1:0] cand,
	output logic                       win
);
	localparam int NW = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);

	logic [LABEL_BITS-1:0] cand_q;
	logic [NW-1:0]         cnt_q;
	logic [NW-1:0]         n_q;
	logic [NW-1:0]         match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			n_q     <= '0;
			match_q <= '0;
		end else if (ctl.clear) begin
			cnt_q   <= '0;
			n_q     <= '0;
			match_q <= '0;
		end else if (ctl.elect) begin
			n_q <= n_q + NW'(1);
			if (cnt_q == '0) begin
				cnt_q <= NW'(1);
			end else if (lbl == cand_q) begin
				cnt_q <= cnt_q + NW'(1);
			end else begin
				cnt_q <= cnt_q - NW'(1);
			end
		end else if (ctl.count && lbl == cand_q) begin
			match_q <= match_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.elect && cnt_q == '0) begin
			cand_q <= lbl;
		end
	end

	assign cand = cand_q;
	assign win  = (n_q != '0) && (cand_q != own) && ({match_q, 1'b0} > {1'b0, n_q});
endmodule
`default_nettype wire

// ===== rtl/label_border_majority_smoother.sv =====
// Cell writes, reads and unknown ops: the result is registered first in the rd_*_s1 stage,
// then in done and the output registers; one item accepted per cycle while not busy, so
// these ops stream back to back. While a run holds busy, every cell, neighbor and window
// read goes through the read address shared by the two registered banks of the store.
// Reset clears the configuration to its defaults and all control state; the cell store
// keeps no reset and needs no clearing pass.
`default_nettype none
`include "label_border_majority_smoother_assert.svh"
module label_border_majority_smoother import lbms_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_RADIUS = 3,
	parameter int LABEL_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [11:0] cell_index,
	input  wire logic        cell_blocked,
	input  wire logic [15:0] cell_label,
	output logic             done,
	output logic [15:0]      label_out,
	output logic [7:0]       passes_done,
	output logic             converged,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT + 1);
	localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int CW    = $clog2(MAXD + MAX_RADIUS + 1) + 1;
	localparam int OW    = $clog2(MAX_RADIUS + 1) + 1;
	localparam int LW    = (LABEL_BITS > 16) ? LABEL_BITS : 16;
	localparam int TW    = AW + 1;
	localparam int CMPW  = (TW > 12) ? TW : 12;
	localparam int PW    = AW + CW;
	localparam int DW    = LABEL_BITS + 1;

	logic [6:0]  grid_width_q;
	logic [6:0]  grid_height_q;
	logic [15:0] first_label_q;
	logic [1:0]  window_radius_q;
	logic [7:0]  max_passes_q;

	state_t state_q, state_d;

	logic signed [CW-1:0] x_q, y_q;
	logic [1:0]           k_q;
	logic signed [OW-1:0] ox_q, oy_q;
	logic                 phase_q;
	logic                 changed_q;
	logic                 bank_q;
	logic [7:0]           pass_q;
	logic                 conv_q;
	logic [LABEL_BITS-1:0] own_q, new_q;
	logic                  cblk_q;

	logic rd_valid_s1, rd_read_s1, rd_hit_s1;
	logic done_q;
	logic [15:0] label_out_q;
	logic [7:0]  passes_out_q;
	logic        conv_out_q;

	logic [XW-1:0] w_eff;
	logic [YW-1:0] h_eff;
	logic signed [OW-1:0] r_s;
	logic signed [CW-1:0] w_s, h_s;
	logic [TW-1:0] total;
	logic          hit;
	logic [AW-1:0] idx_addr;

	logic signed [CW-1:0] nbx, nby, wx, wy;
	logic nb_in, win_in, last_pos, last_cell;

	logic [DW-1:0] rd0, rd1, rd_word;
	logic [LABEL_BITS-1:0] rd_lbl;
	logic rd_blk, take, border;

	logic          ram_we0, ram_we1;
	logic [AW-1:0] ram_raddr, ram_waddr;
	logic [DW-1:0] ram_wdata;

	vote_ctl_t vote_ctl;
	logic [LABEL_BITS-1:0] vote_cand;
	logic vote_win;
	logic accept;

	function automatic logic [AW-1:0] cell_addr(input logic signed [CW-1:0] cx,
		input logic signed [CW-1:0] cy, input logic [XW-1:0] w);
		logic [PW-1:0] p;
		p = PW'($unsigned(cy)) * PW'(w) + PW'($unsigned(cx));
		return p[AW-1:0];
	endfunction

	function automatic logic on_grid(input logic signed [CW-1:0] cx,
		input logic signed [CW-1:0] cy, input logic signed [CW-1:0] w,
		input logic signed [CW-1:0] h);
		return (cx >= 0) && (cy >= 0) && (cx < w) && (cy < h);
	endfunction

	always_comb begin
		if (int'(grid_width_q) > MAX_WIDTH) begin
			w_eff = XW'(MAX_WIDTH);
		end else begin
			w_eff = XW'(grid_width_q);
		end
		if (int'(grid_height_q) > MAX_HEIGHT) begin
			h_eff = YW'(MAX_HEIGHT);
		end else begin
			h_eff = YW'(grid_height_q);
		end
		if (int'(window_radius_q) > MAX_RADIUS) begin
			r_s = OW'(MAX_RADIUS);
		end else begin
			r_s = OW'(window_radius_q);
		end
	end

	assign w_s      = $signed(CW'(w_eff));
	assign h_s      = $signed(CW'(h_eff));
	assign total    = TW'(w_eff * h_eff);
	assign hit      = CMPW'(cell_index) < CMPW'(total);
	assign idx_addr = AW'(cell_index);
	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;

	always_comb begin
		nbx = x_q;
		nby = y_q;
		case (k_q)
			2'd0: nbx = x_q + CW'(1);
			2'd1: nbx = x_q - CW'(1);
			2'd2: nby = y_q + CW'(1);
			default: nby = y_q - CW'(1);
		endcase
	end

	assign wx        = x_q + CW'(ox_q);
	assign wy        = y_q + CW'(oy_q);
	assign nb_in     = on_grid(nbx, nby, w_s, h_s);
	assign win_in    = on_grid(wx, wy, w_s, h_s);
	assign last_pos  = (ox_q == r_s) && (oy_q == r_s);
	assign last_cell = (x_q == w_s - CW'(1)) && (y_q == h_s - CW'(1));

	assign rd_word = bank_q ? rd1 : rd0;
	assign rd_lbl  = rd_word[LABEL_BITS-1:0];
	assign rd_blk  = rd_word[LABEL_BITS];
	assign take    = !rd_blk && (LW'(rd_lbl) >= LW'(first_label_q));
	assign border  = !rd_blk && ((LW'(rd_lbl) < LW'(first_label_q)) || (rd_lbl != own_q));

	lbms_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_bank0 (
		.clk  (clk),
		.we   (ram_we0),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd0)
	);

	lbms_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_bank1 (
		.clk  (clk),
		.we   (ram_we1),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd1)
	);

	lbms_vote #(.LABEL_BITS(LABEL_BITS), .MAX_RADIUS(MAX_RADIUS)) u_vote (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (vote_ctl),
		.lbl   (rd_lbl),
		.own   (own_q),
		.cand  (vote_cand),
		.win   (vote_win)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && op == OP_RUN) begin
					state_d = S_RUN_INIT;
				end
			end
			S_RUN_INIT: begin
				if (total == '0 || max_passes_q == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_CELL_RD;
				end
			end
			S_CELL_RD: state_d = S_CELL_CHK;
			S_CELL_CHK: state_d = take ? S_NB_RD : S_WR;
			S_NB_RD: begin
				if (nb_in) begin
					state_d = S_NB_CHK;
				end else if (k_q == 2'd3) begin
					state_d = S_WR;
				end
			end
			S_NB_CHK: begin
				if (border) begin
					state_d = S_WIN_RD;
				end else if (k_q == 2'd3) begin
					state_d = S_WR;
				end else begin
					state_d = S_NB_RD;
				end
			end
			S_WIN_RD: begin
				if (win_in) begin
					state_d = S_WIN_CHK;
				end else if (last_pos && phase_q) begin
					state_d = S_DECIDE;
				end
			end
			S_WIN_CHK: begin
				if (last_pos && phase_q) begin
					state_d = S_DECIDE;
				end else begin
					state_d = S_WIN_RD;
				end
			end
			S_DECIDE: state_d = S_WR;
			S_WR: state_d = last_cell ? S_PASS_END : S_CELL_RD;
			S_PASS_END: begin
				if (!changed_q || (pass_q + 8'd1) == max_passes_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_CELL_RD;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_raddr = cell_addr(x_q, y_q, w_eff);
		ram_waddr = cell_addr(x_q, y_q, w_eff);
		ram_wdata = {cblk_q, new_q};
		ram_we0   = 1'b0;
		ram_we1   = 1'b0;
		vote_ctl  = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = idx_addr;
				ram_waddr = idx_addr;
				ram_wdata = {cell_blocked, LABEL_BITS'(cell_label)};
				ram_we0   = accept && op == OP_WRITE && hit;
				ram_we1   = accept && op == OP_WRITE && hit;
			end
			S_NB_RD: ram_raddr = cell_addr(nbx, nby, w_eff);
			S_NB_CHK: vote_ctl.clear = border;
			S_WIN_RD: ram_raddr = cell_addr(wx, wy, w_eff);
			S_WIN_CHK: begin
				vote_ctl.elect = take && !phase_q;
				vote_ctl.count = take && phase_q;
			end
			S_WR: begin
				ram_we0 = bank_q;
				ram_we1 = !bank_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= 7'd64;
			grid_height_q   <= 7'd64;
			first_label_q   <= '0;
			window_radius_q <= 2'd1;
			max_passes_q    <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:    grid_width_q    <= cfg_data[6:0];
				REG_GRID_HEIGHT:   grid_height_q   <= cfg_data[6:0];
				REG_FIRST_LABEL:   first_label_q   <= cfg_data;
				REG_WINDOW_RADIUS: window_radius_q <= cfg_data[1:0];
				REG_MAX_PASSES:    max_passes_q    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			x_q         <= '0;
			y_q         <= '0;
			k_q         <= '0;
			ox_q        <= '0;
			oy_q        <= '0;
			phase_q     <= 1'b0;
			changed_q   <= 1'b0;
			bank_q      <= 1'b0;
			pass_q      <= '0;
			conv_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_read_s1  <= 1'b0;
			rd_hit_s1   <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= accept && op != OP_RUN;
			rd_read_s1  <= op == OP_READ;
			rd_hit_s1   <= hit;
			done_q      <= rd_valid_s1 || state_q == S_DONE;
			unique case (state_q)
				S_RUN_INIT: begin
					x_q       <= '0;
					y_q       <= '0;
					pass_q    <= '0;
					conv_q    <= 1'b0;
					changed_q <= 1'b0;
				end
				S_CELL_CHK: k_q <= '0;
				S_NB_RD: begin
					if (!nb_in) begin
						k_q <= k_q + 2'd1;
					end
				end
				S_NB_CHK: begin
					k_q     <= k_q + 2'd1;
					ox_q    <= -r_s;
					oy_q    <= -r_s;
					phase_q <= 1'b0;
				end
				S_WIN_RD, S_WIN_CHK: begin
					if ((state_q == S_WIN_CHK) || !win_in) begin
						if (last_pos) begin
							ox_q    <= -r_s;
							oy_q    <= -r_s;
							phase_q <= 1'b1;
						end else if (ox_q == r_s) begin
							ox_q <= -r_s;
							oy_q <= oy_q + OW'(1);
						end else begin
							ox_q <= ox_q + OW'(1);
						end
					end
				end
				S_DECIDE: begin
					if (vote_win) begin
						changed_q <= 1'b1;
					end
				end
				S_WR: begin
					if (x_q == w_s - CW'(1)) begin
						x_q <= '0;
						y_q <= y_q + CW'(1);
					end else begin
						x_q <= x_q + CW'(1);
					end
				end
				S_PASS_END: begin
					bank_q    <= !bank_q;
					pass_q    <= pass_q + 8'd1;
					conv_q    <= !changed_q;
					changed_q <= 1'b0;
					x_q       <= '0;
					y_q       <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CELL_CHK) begin
			own_q  <= rd_lbl;
			new_q  <= rd_lbl;
			cblk_q <= rd_blk;
		end else if (state_q == S_DECIDE && vote_win) begin
			new_q <= vote_cand;
		end
		if (rd_valid_s1) begin
			label_out_q  <= (rd_read_s1 && rd_hit_s1) ? 16'(rd_lbl) : 16'd0;
			passes_out_q <= '0;
			conv_out_q   <= 1'b0;
		end else if (state_q == S_DONE) begin
			label_out_q  <= '0;
			passes_out_q <= pass_q;
			conv_out_q   <= conv_q;
		end
	end

	assign done        = done_q;
	assign label_out   = label_out_q;
	assign passes_done = passes_out_q;
	assign converged   = conv_out_q;

	`LBMS_ASSERT_IMP(a_pipe_empty_in_run, clk, arst_n, busy, !rd_valid_s1, "Cell beat pending during a run.")
	`LBMS_ASSERT_NXT(a_bank_stable, clk, arst_n, busy && state_q != S_PASS_END, $stable(bank_q), "Bank swapped inside a pass.")
	`LBMS_ASSERT_IMP(a_conv_has_pass, clk, arst_n, done && converged, passes_done != 8'd0, "Converged without a pass.")
endmodule
`default_nettype wire
